### rtl/core/ppa_pkg.sv
// ---------------------------------------------------------------------------
// ppa_pkg
// Shared constants, status codes and control/status types of the page
// allocator.
// ---------------------------------------------------------------------------
package ppa_pkg;

   localparam int MAX_PAGES  = 8192;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_W     = 32;
   localparam int REG_W      = 14;
   localparam int BIT_W      = 5;
   localparam int WORD_BITS  = 1 << BIT_W;
   localparam int WORDS      = MAX_PAGES / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORDS);
   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int STATUS_W   = 3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOMEM      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD   = 3'd4;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic REG_PAGE_TOTAL  = 1'b0;
   localparam logic REG_FIRST_ALLOC = 1'b1;

   typedef struct packed {
      logic                load;
      logic                rd;
      logic                adv;
      logic                wr_alloc;
      logic                wr_rel;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_release;
      logic empty;
      logic misaligned;
      logic out_of_range;
      logic hit;
      logic last_word;
      logic held;
   } dp_sts_type;

endpackage

### rtl/core/ppa_ram.sv
// ---------------------------------------------------------------------------
// ppa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ppa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/ppa_datapath.sv
// ---------------------------------------------------------------------------
// ppa_datapath
// Bitmap storage, word scan, release checks, page count and result registers.
// ---------------------------------------------------------------------------
module ppa_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ppa_pkg::dp_cmd_type             cmd,
   output ppa_pkg::dp_sts_type             sts,
   input  logic                            req_command,
   input  logic [ppa_pkg::ADDR_W-1:0]      req_page_address,
   input  logic [ppa_pkg::REG_W-1:0]       page_total,
   input  logic [ppa_pkg::REG_W-1:0]       first_allocatable,
   output logic [ppa_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic [ppa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ppa_pkg::REG_W-1:0]       rsp_free_count
);

   localparam int WB = ppa_pkg::WORD_BITS;
   localparam int AW = ppa_pkg::WORD_AW;
   localparam int RW = ppa_pkg::REG_W;
   localparam int PS = ppa_pkg::PAGE_SHIFT;
   localparam int IW = ppa_pkg::IDX_W;
   localparam int BW = ppa_pkg::BIT_W;
   localparam int XW = ppa_pkg::ADDR_W - PS;

   logic                           cmd_ff,   cmd_in;
   logic [ppa_pkg::ADDR_W-1:0]     addr_ff,  addr_in;
   logic [AW-1:0]                  ptr_ff,   ptr_in;
   logic [RW-1:0]                  count_ff, count_in;
   logic [ppa_pkg::WORDS-1:0]      valid_ff, valid_in;
   logic                           vrd_ff,   vrd_in;
   logic [ppa_pkg::ADDR_W-1:0]     grant_ff, grant_in;
   logic [ppa_pkg::STATUS_W-1:0]   stat_ff,  stat_in;
   logic [ppa_pkg::ADDR_W-1:0]     out_addr_ff, out_addr_in;
   logic [ppa_pkg::STATUS_W-1:0]   out_stat_ff, out_stat_in;
   logic [RW-1:0]                  out_free_ff, out_free_in;

   logic [RW-1:0]   top_eff, low_eff, top_m1, span, free_now;
   logic [WB-1:0]   ram_q, word, avail, lowest, wdata;
   logic [BW-1:0]   enc, rel_bit;
   logic [XW-1:0]   rel_idx;
   logic [IW:0]     page;
   logic            we;

   assign top_eff = (page_total > RW'(ppa_pkg::MAX_PAGES)) ?
                    RW'(ppa_pkg::MAX_PAGES) : page_total;
   assign low_eff = (first_allocatable > RW'(ppa_pkg::MAX_PAGES)) ?
                    RW'(ppa_pkg::MAX_PAGES) : first_allocatable;
   assign top_m1  = top_eff - RW'(1);

   assign word = vrd_ff ? ram_q : '0;

   always_comb begin
      for (int b = 0; b < WB; b++) begin
         page     = {1'b0, ptr_ff, BW'(b)};
         avail[b] = !word[b] && (RW'(page) >= low_eff) && (RW'(page) < top_eff);
      end
   end

   assign lowest = avail & (~avail + WB'(1));

   always_comb begin
      enc = '0;
      for (int b = 0; b < WB; b++) begin
         if (lowest[b]) begin
            enc = enc | BW'(b);
         end
      end
   end

   assign rel_idx = addr_ff[ppa_pkg::ADDR_W-1:PS];
   assign rel_bit = addr_ff[PS+BW-1:PS];

   assign sts.is_release   = (cmd_ff == ppa_pkg::CMD_RELEASE);
   assign sts.empty        = (low_eff >= top_eff);
   assign sts.misaligned   = |addr_ff[PS-1:0];
   assign sts.out_of_range = (rel_idx < XW'(low_eff)) || (rel_idx >= XW'(top_eff));
   assign sts.hit          = |avail;
   assign sts.last_word    = (ptr_ff == top_m1[IW-1:BW]);
   assign sts.held         = word[rel_bit];

   assign we    = cmd.wr_alloc || cmd.wr_rel;
   assign wdata = cmd.wr_alloc ? (word | lowest) : (word & ~(WB'(1) << rel_bit));

   ppa_ram #(
      .WIDTH (WB),
      .DEPTH (ppa_pkg::WORDS)
   ) u_bitmap (
      .clock (clock),
      .we    (we),
      .waddr (ptr_ff),
      .wdata (wdata),
      .raddr (ptr_ff),
      .rdata (ram_q)
   );

   assign span     = (top_eff > low_eff) ? (top_eff - low_eff) : '0;
   assign free_now = (span > count_ff) ? (span - count_ff) : '0;

   always_comb begin
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      ptr_in      = ptr_ff;
      count_in    = count_ff;
      valid_in    = valid_ff;
      vrd_in      = vrd_ff;
      grant_in    = grant_ff;
      stat_in     = stat_ff;
      out_addr_in = out_addr_ff;
      out_stat_in = out_stat_ff;
      out_free_in = out_free_ff;
      if (cmd.load) begin
         cmd_in   = req_command;
         addr_in  = req_page_address;
         grant_in = '0;
         ptr_in   = (req_command == ppa_pkg::CMD_RELEASE) ?
                    req_page_address[PS+IW-1:PS+BW] : low_eff[IW-1:BW];
      end
      if (cmd.rd) begin
         vrd_in = valid_ff[ptr_ff];
      end
      if (cmd.adv) begin
         ptr_in = ptr_ff + AW'(1);
      end
      if (we) begin
         valid_in[ptr_ff] = 1'b1;
      end
      if (cmd.wr_alloc) begin
         count_in = count_ff + RW'(1);
         grant_in = {{(ppa_pkg::ADDR_W-IW-PS){1'b0}}, ptr_ff, enc, {PS{1'b0}}};
      end
      if (cmd.wr_rel && (count_ff != '0)) begin
         count_in = count_ff - RW'(1);
      end
      if (cmd.set_status) begin
         stat_in = cmd.status;
      end
      if (cmd.out_load) begin
         out_addr_in = grant_ff;
         out_stat_in = stat_ff;
         out_free_in = free_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      ptr_ff      <= ptr_in;
      vrd_ff      <= vrd_in;
      grant_ff    <= grant_in;
      stat_ff     <= stat_in;
      out_addr_ff <= out_addr_in;
      out_stat_ff <= out_stat_in;
      out_free_ff <= out_free_in;
   end

   assign rsp_granted_address = out_addr_ff;
   assign rsp_status          = out_stat_ff;
   assign rsp_free_count      = out_free_ff;

endmodule

### rtl/core/ppa_ctrl.sv
// ---------------------------------------------------------------------------
// ppa_ctrl
// Request sequencer: scan, release check and result handoff.
// ---------------------------------------------------------------------------
module ppa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ppa_pkg::dp_cmd_type cmd,
   input  ppa_pkg::dp_sts_type sts
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_ALLOC_RD  = 3'd1;
   localparam logic [2:0] S_ALLOC_CHK = 3'd2;
   localparam logic [2:0] S_REL_RD    = 3'd3;
   localparam logic [2:0] S_REL_CHK   = 3'd4;
   localparam logic [2:0] S_RESP      = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_ALLOC_RD;
            end
         end
         S_ALLOC_RD: begin
            if (sts.is_release) begin
               state_in = S_REL_RD;
            end else if (sts.empty) begin
               cmd.set_status = 1'b1;
               cmd.status     = ppa_pkg::ST_NOMEM;
               state_in       = S_RESP;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_ALLOC_CHK;
            end
         end
         S_ALLOC_CHK: begin
            if (sts.hit) begin
               cmd.wr_alloc   = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = ppa_pkg::ST_OK;
               state_in       = S_RESP;
            end else if (sts.last_word) begin
               cmd.set_status = 1'b1;
               cmd.status     = ppa_pkg::ST_NOMEM;
               state_in       = S_RESP;
            end else begin
               cmd.adv  = 1'b1;
               state_in = S_ALLOC_RD;
            end
         end
         S_REL_RD: begin
            if (sts.misaligned) begin
               cmd.set_status = 1'b1;
               cmd.status     = ppa_pkg::ST_MISALIGNED;
               state_in       = S_RESP;
            end else if (sts.out_of_range) begin
               cmd.set_status = 1'b1;
               cmd.status     = ppa_pkg::ST_RANGE;
               state_in       = S_RESP;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_REL_CHK;
            end
         end
         S_REL_CHK: begin
            cmd.set_status = 1'b1;
            if (sts.held) begin
               cmd.wr_rel = 1'b1;
               cmd.status = ppa_pkg::ST_OK;
            end else begin
               cmd.status = ppa_pkg::ST_NOT_HELD;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/physical_page_allocator_core.sv
// ---------------------------------------------------------------------------
// physical_page_allocator_core
// First-fit page frame allocator over a bitmap of in-use marks, with
// page-total and first-page control registers.
// ---------------------------------------------------------------------------
//  channel  ports                                          direction
//  req      req_valid/ready, command, page_address         in
//  rsp      rsp_valid/ready, granted_address, status, free out
//  csr      csr_psel/penable/pwrite/paddr/pwdata/prdata    in/out
//
//  Allocate: a read state and a check state per 32-page bitmap word, first-fit
//  from the first allocatable page; NOMEM with no scan if the window is empty.
//  Release: alignment and range checks, then a word read and a held-bit check.
//  Reset is instant: per-word valid flags stand in for a clear of the RAM.
//  A finished request waits in the output register; the next request is
//  taken once the current one reaches that register.
// ---------------------------------------------------------------------------
module physical_page_allocator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [ppa_pkg::ADDR_W-1:0]       req_page_address,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ppa_pkg::ADDR_W-1:0]       rsp_granted_address,
   output logic [ppa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ppa_pkg::REG_W-1:0]        rsp_free_count,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [2:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   ppa_pkg::dp_cmd_type cmd;
   ppa_pkg::dp_sts_type sts;

   logic [ppa_pkg::REG_W-1:0] total_ff, total_in;
   logic [ppa_pkg::REG_W-1:0] first_ff, first_in;
   logic                      wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      total_in = total_ff;
      first_in = first_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            ppa_pkg::REG_PAGE_TOTAL:  total_in = csr_pwdata[ppa_pkg::REG_W-1:0];
            ppa_pkg::REG_FIRST_ALLOC: first_in = csr_pwdata[ppa_pkg::REG_W-1:0];
            default:                  total_in = total_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         ppa_pkg::REG_PAGE_TOTAL:  csr_prdata = 32'(total_ff);
         ppa_pkg::REG_FIRST_ALLOC: csr_prdata = 32'(first_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= ppa_pkg::REG_W'(8192);
         first_ff <= ppa_pkg::REG_W'(257);
      end else begin
         total_ff <= total_in;
         first_ff <= first_in;
      end
   end

   ppa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ppa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_command         (req_command),
      .req_page_address    (req_page_address),
      .page_total          (total_ff),
      .first_allocatable   (first_ff),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .rsp_free_count      (rsp_free_count)
   );

endmodule
